/* rtl/core/astl_pkg.sv */
// ----------------------------------------------------------------------------
// astl_pkg: shared types and constants for the address to symbol lookup
// Beat layouts, command codes, table entry layouts and scan control bundle.
// ----------------------------------------------------------------------------
package astl_pkg;

   // Default table depths
   localparam int FUNC_ENTRIES_DEF = 1024;
   localparam int LINE_ENTRIES_DEF = 4096;

   // Field widths fixed by the interface
   localparam int ADDR_W   = 64;
   localparam int LEN_W    = 32;
   localparam int LINE_W   = 24;
   localparam int COL_W    = 16;
   localparam int FILE_W   = 16;
   localparam int SLOT_W   = 10;
   localparam int CMD_W    = 2;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD_FUNC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_LINE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [LINE_W-1:0] line_number;
      logic [COL_W-1:0]  column_number;
      logic [FILE_W-1:0] file_index;
   } req_type;

   typedef struct packed {
      logic              table_full;
      logic              function_found;
      logic [SLOT_W-1:0] function_slot;
      logic [ADDR_W-1:0] function_start;
      logic [LEN_W-1:0]  function_length;
      logic              line_found;
      logic [LINE_W-1:0] line_out;
      logic [COL_W-1:0]  column_out;
      logic [FILE_W-1:0] file_out;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  length;
   } func_entry_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [LINE_W-1:0] line;
      logic [COL_W-1:0]  column;
      logic [FILE_W-1:0] file;
   } line_entry_type;

   // Control for the shared scan comparator
   typedef struct packed {
      logic have_best;  // a best candidate is already held
      logic strict;     // candidate must lie strictly below the limit
   } cmp_ctl_type;

endpackage

/* rtl/core/astl_scan_cmp.sv */
// ----------------------------------------------------------------------------
// astl_scan_cmp: shared predecessor comparator
// Decides whether a table candidate replaces the current best predecessor.
// ----------------------------------------------------------------------------
module astl_scan_cmp (
   input  astl_pkg::cmp_ctl_type            ctl,
   input  logic [astl_pkg::ADDR_W-1:0]      cand,
   input  logic [astl_pkg::ADDR_W-1:0]      limit,
   input  logic [astl_pkg::ADDR_W-1:0]      best,
   output logic                             take
);

   logic below;
   logic better;

   // Check the bound: at or below for functions, strictly below for lines
   assign below  = ctl.strict ? (cand < limit) : (cand <= limit);
   // Replace only on a strictly greater address so the earliest entry wins ties
   assign better = !ctl.have_best || (cand > best);
   assign take   = below && better;

endmodule

/* rtl/core/address_to_symbol_lookup.sv */
// ----------------------------------------------------------------------------
// address_to_symbol_lookup: function and line table lookup by address
// Inserts fill a function table and a line table; a query finds the nearest
// preceding function and line record with one shared comparator.
// ----------------------------------------------------------------------------
// Insert: taken in the idle state, then the result state loads the output register.
// Query: function scan, function check, line scan, line check, result; the line
//   scan is skipped on a function miss. One table entry is read and compared per
//   cycle, so the table read ports and the shared comparator set the rate.
// One item is in work at a time; the next is taken once the result is queued.
// Reset empties both tables at once by clearing the fill counts; no clear pass.
// ----------------------------------------------------------------------------
module address_to_symbol_lookup #(
   parameter int FUNC_ENTRIES = astl_pkg::FUNC_ENTRIES_DEF,
   parameter int LINE_ENTRIES = astl_pkg::LINE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  astl_pkg::req_type                  req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output astl_pkg::rsp_type                  rsp_data,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [astl_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [astl_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [astl_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);

   localparam int FIDX_W  = (FUNC_ENTRIES > 1) ? $clog2(FUNC_ENTRIES) : 1;
   localparam int LIDX_W  = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;
   localparam int FCNT_W  = $clog2(FUNC_ENTRIES + 1);
   localparam int LCNT_W  = $clog2(LINE_ENTRIES + 1);
   localparam int SCNT_W  = (FCNT_W > LCNT_W) ? FCNT_W : LCNT_W;
   localparam int AW      = astl_pkg::ADDR_W;
   localparam int LW      = astl_pkg::LEN_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FSCAN  = 3'd1;
   localparam logic [2:0] S_FCHECK = 3'd2;
   localparam logic [2:0] S_LSCAN  = 3'd3;
   localparam logic [2:0] S_LCHECK = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   // tables
   astl_pkg::func_entry_type func_mem [FUNC_ENTRIES];
   astl_pkg::line_entry_type line_mem [LINE_ENTRIES];

   logic [2:0]               state_ff, state_in;
   logic [FCNT_W-1:0]        func_count_ff, func_count_in;
   logic [LCNT_W-1:0]        rec_count_ff, rec_count_in;
   logic [AW-1:0]            load_base_ff, load_base_in;
   logic [AW-1:0]            taddr_ff, taddr_in;
   logic [SCNT_W-1:0]        idx_ff, idx_in;
   logic [SCNT_W-1:0]        rd_idx_ff;
   logic                     pend_ff, pend_in;
   astl_pkg::func_entry_type func_rd_ff;
   astl_pkg::line_entry_type line_rd_ff;

   logic                     fhave_ff, fhave_in;
   logic [FIDX_W-1:0]        fslot_ff, fslot_in;
   astl_pkg::func_entry_type fbest_ff, fbest_in;
   logic                     lhave_ff, lhave_in;
   astl_pkg::line_entry_type lbest_ff, lbest_in;
   logic                     fhit_ff, fhit_in;
   logic                     lhit_ff, lhit_in;
   logic                     full_ff, full_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   astl_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic                     func_wr, line_wr;
   logic                     rd_en;
   logic [AW-1:0]            span_diff;
   logic [31:0]              slot_wide;
   astl_pkg::cmp_ctl_type    cmp_ctl;
   logic [AW-1:0]            cmp_cand;
   logic [AW-1:0]            cmp_best;
   logic                     cmp_take;
   logic                     csr_wr;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Register port: one 64-bit register, zero wait states
   assign csr_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;
   assign prdata = (paddr == '0) ? load_base_ff : '0;

   // Insert writes land at the current fill count
   assign func_wr = accept && (req_data.command == astl_pkg::CMD_ADD_FUNC)
                    && (func_count_ff < FCNT_W'(FUNC_ENTRIES));
   assign line_wr = accept && (req_data.command == astl_pkg::CMD_ADD_LINE)
                    && (rec_count_ff < LCNT_W'(LINE_ENTRIES));

   // Issue one table read per cycle while the scan index is below the count
   always_comb begin
      rd_en = 1'b0;
      if (state_ff == S_FSCAN) begin
         rd_en = (idx_ff < SCNT_W'(func_count_ff));
      end else if (state_ff == S_LSCAN) begin
         rd_en = (idx_ff < SCNT_W'(rec_count_ff));
      end
   end

   // Table write and registered read
   always_ff @(posedge clock) begin
      if (func_wr) begin
         func_mem[func_count_ff[FIDX_W-1:0]] <= '{start: req_data.address,
                                                 length: req_data.length};
      end
      if (rd_en && (state_ff == S_FSCAN)) begin
         func_rd_ff <= func_mem[idx_ff[FIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (line_wr) begin
         line_mem[rec_count_ff[LIDX_W-1:0]] <= '{address: req_data.address,
                                                 line: req_data.line_number,
                                                 column: req_data.column_number,
                                                 file: req_data.file_index};
      end
      if (rd_en && (state_ff == S_LSCAN)) begin
         line_rd_ff <= line_mem[idx_ff[LIDX_W-1:0]];
      end
   end

   // Shared comparator operands follow the active scan
   always_comb begin
      cmp_ctl.strict = (state_ff == S_LSCAN);
      if (state_ff == S_LSCAN) begin
         cmp_ctl.have_best = lhave_ff;
         cmp_cand          = line_rd_ff.address;
         cmp_best          = lbest_ff.address;
      end else begin
         cmp_ctl.have_best = fhave_ff;
         cmp_cand          = func_rd_ff.start;
         cmp_best          = fbest_ff.start;
      end
   end

   astl_scan_cmp u_cmp (
      .ctl   (cmp_ctl),
      .cand  (cmp_cand),
      .limit (taddr_ff),
      .best  (cmp_best),
      .take  (cmp_take)
   );

   // Offset of the query from the chosen function start
   assign span_diff = taddr_ff - fbest_ff.start;
   assign slot_wide = 32'(fslot_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      func_count_in = func_count_ff;
      rec_count_in  = rec_count_ff;
      load_base_in  = load_base_ff;
      taddr_in      = taddr_ff;
      idx_in        = idx_ff;
      pend_in       = rd_en;
      fhave_in      = fhave_ff;
      fslot_in      = fslot_ff;
      fbest_in      = fbest_ff;
      lhave_in      = lhave_ff;
      lbest_in      = lbest_ff;
      fhit_in       = fhit_ff;
      lhit_in       = lhit_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (csr_wr) begin
         load_base_in = pwdata;
      end
      if (rd_en) begin
         idx_in = idx_ff + SCNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               taddr_in = req_data.address - load_base_ff;
               idx_in   = '0;
               fhave_in = 1'b0;
               lhave_in = 1'b0;
               fhit_in  = 1'b0;
               lhit_in  = 1'b0;
               full_in  = 1'b0;
               state_in = S_RESULT;
               if (req_data.command == astl_pkg::CMD_ADD_FUNC) begin
                  if (func_wr) begin
                     func_count_in = func_count_ff + FCNT_W'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end else if (req_data.command == astl_pkg::CMD_ADD_LINE) begin
                  if (line_wr) begin
                     rec_count_in = rec_count_ff + LCNT_W'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end else if (req_data.command == astl_pkg::CMD_QUERY) begin
                  state_in = S_FSCAN;
               end
            end
         end
         S_FSCAN: begin
            // fold the returning entry into the best predecessor
            if (pend_ff && cmp_take) begin
               fhave_in = 1'b1;
               fslot_in = rd_idx_ff[FIDX_W-1:0];
               fbest_in = func_rd_ff;
            end
            if (!rd_en && !pend_ff) begin
               state_in = S_FCHECK;
            end
         end
         S_FCHECK: begin
            // hit when the query lies within start + length, no wrap
            idx_in = '0;
            if (fhave_ff && (span_diff[AW-1:LW] == '0)
                && (span_diff[LW-1:0] <= fbest_ff.length)) begin
               fhit_in  = 1'b1;
               state_in = S_LSCAN;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_LSCAN: begin
            if (pend_ff && cmp_take) begin
               lhave_in = 1'b1;
               lbest_in = line_rd_ff;
            end
            if (!rd_en && !pend_ff) begin
               state_in = S_LCHECK;
            end
         end
         S_LCHECK: begin
            // record lies below the query, so only the lower bound is open
            lhit_in  = lhave_ff && (lbest_ff.address > fbest_ff.start);
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in                 = '0;
               rsp_data_in.table_full      = full_ff;
               rsp_data_in.function_found  = fhit_ff;
               rsp_data_in.line_found      = lhit_ff;
               if (fhit_ff) begin
                  rsp_data_in.function_slot   = slot_wide[astl_pkg::SLOT_W-1:0];
                  rsp_data_in.function_start  = fbest_ff.start;
                  rsp_data_in.function_length = fbest_ff.length;
               end
               if (lhit_ff) begin
                  rsp_data_in.line_out   = lbest_ff.line;
                  rsp_data_in.column_out = lbest_ff.column;
                  rsp_data_in.file_out   = lbest_ff.file;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         func_count_ff <= '0;
         rec_count_ff  <= '0;
         load_base_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         func_count_ff <= func_count_in;
         rec_count_ff  <= rec_count_in;
         load_base_ff  <= load_base_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      taddr_ff    <= taddr_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= idx_ff;
      fhave_ff    <= fhave_in;
      fslot_ff    <= fslot_in;
      fbest_ff    <= fbest_in;
      lhave_ff    <= lhave_in;
      lbest_ff    <= lbest_in;
      fhit_ff     <= fhit_in;
      lhit_ff     <= lhit_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Fill counts never pass the table depth
   a_func_count: assert property (@(posedge clock) disable iff (reset)
      func_count_ff <= FCNT_W'(FUNC_ENTRIES))
      else $error("function count beyond table depth");

   a_rec_count: assert property (@(posedge clock) disable iff (reset)
      rec_count_ff <= LCNT_W'(LINE_ENTRIES))
      else $error("line record count beyond table depth");

   // A read in flight belongs to one of the scans
   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_FSCAN) || (state_ff == S_LSCAN))
      else $error("table read outstanding outside a scan");

   // An accepted beat always leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start work");

   // A line hit only follows a function hit
   a_line_needs_func: assert property (@(posedge clock) disable iff (reset)
      lhit_ff |-> fhit_ff)
      else $error("line hit without function hit");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the address to symbol lookup
// Drives inserts and queries with random gaps on both channels, predicts each
// result from a shadow copy of both tables and of load_base, and compares
// every result beat field by field. Covers range edges, ties, wrap of the
// load base subtraction and unused commands.
// ----------------------------------------------------------------------------
module tb;

   localparam int FUNC_ENTRIES = astl_pkg::FUNC_ENTRIES_DEF;
   localparam int LINE_ENTRIES = astl_pkg::LINE_ENTRIES_DEF;
   localparam logic [astl_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [astl_pkg::CSR_ADDR_W-1:0] LOAD_BASE_ADDR = 3'd0;
   localparam int STALL_LIMIT = 30000;
   localparam int REPORT_MAX = 10;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   astl_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   astl_pkg::rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [astl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [astl_pkg::CSR_DATA_W-1:0] pwdata;
   logic [astl_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   // shadow tables and register
   logic [astl_pkg::ADDR_W-1:0] fn_start_mem [FUNC_ENTRIES];
   logic [astl_pkg::LEN_W-1:0]  fn_len_mem [FUNC_ENTRIES];
   int fn_used = 0;
   logic [astl_pkg::ADDR_W-1:0] ln_addr_mem [LINE_ENTRIES];
   logic [astl_pkg::LINE_W-1:0] ln_line_mem [LINE_ENTRIES];
   logic [astl_pkg::COL_W-1:0]  ln_col_mem [LINE_ENTRIES];
   logic [astl_pkg::FILE_W-1:0] ln_file_mem [LINE_ENTRIES];
   int ln_used = 0;
   logic [astl_pkg::ADDR_W-1:0] base_shadow = '0;

   astl_pkg::rsp_type pending_results [$];
   astl_pkg::rsp_type want_rsp;
   int mismatch_count = 0;
   int stall_cycles = 0;
   bit steady_flow = 1'b0;

   address_to_symbol_lookup dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one command to the shadow tables and return the result it causes
   function automatic astl_pkg::rsp_type predict_lookup(input astl_pkg::req_type item);
      astl_pkg::rsp_type res;
      logic [astl_pkg::ADDR_W-1:0] xlat;
      logic [astl_pkg::ADDR_W-1:0] fs;
      logic [astl_pkg::LEN_W-1:0] fl;
      int fn;
      int rec;
      int i;
      bit have_fn;
      bit have_rec;
      res = '0;
      fn = 0;
      rec = 0;
      have_fn = 1'b0;
      have_rec = 1'b0;
      case (item.command)
         astl_pkg::CMD_ADD_FUNC: begin
            if (fn_used >= FUNC_ENTRIES) begin
               res.table_full = 1'b1;
            end else begin
               fn_start_mem[fn_used] = item.address;
               fn_len_mem[fn_used] = item.length;
               fn_used++;
            end
         end
         astl_pkg::CMD_ADD_LINE: begin
            if (ln_used >= LINE_ENTRIES) begin
               res.table_full = 1'b1;
            end else begin
               ln_addr_mem[ln_used] = item.address;
               ln_line_mem[ln_used] = item.line_number;
               ln_col_mem[ln_used] = item.column_number;
               ln_file_mem[ln_used] = item.file_index;
               ln_used++;
            end
         end
         astl_pkg::CMD_QUERY: begin
            xlat = item.address - base_shadow;
            // nearest function at or below, earliest wins on equal starts
            for (i = 0; i < fn_used; i++) begin
               if (fn_start_mem[i] <= xlat &&
                   (!have_fn || fn_start_mem[i] > fn_start_mem[fn])) begin
                  have_fn = 1'b1;
                  fn = i;
               end
            end
            fs = fn_start_mem[fn];
            fl = fn_len_mem[fn];
            if (have_fn && (xlat - fs) <= {32'd0, fl}) begin
               res.function_found = 1'b1;
               res.function_slot = fn[astl_pkg::SLOT_W-1:0];
               res.function_start = fs;
               res.function_length = fl;
               // nearest line record strictly below, earliest wins on ties
               for (i = 0; i < ln_used; i++) begin
                  if (ln_addr_mem[i] < xlat &&
                      (!have_rec || ln_addr_mem[i] > ln_addr_mem[rec])) begin
                     have_rec = 1'b1;
                     rec = i;
                  end
               end
               if (have_rec && ln_addr_mem[rec] > fs &&
                   (ln_addr_mem[rec] - fs) <= {32'd0, fl}) begin
                  res.line_found = 1'b1;
                  res.line_out = ln_line_mem[rec];
                  res.column_out = ln_col_mem[rec];
                  res.file_out = ln_file_mem[rec];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // Predict on each accepted request beat, check each accepted result beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            pending_results.push_back(predict_lookup(req_data));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("%0t: result beat with nothing pending", $realtime);
            end else begin
               want_rsp = pending_results.pop_front();
               note_field("table_full", 64'(want_rsp.table_full),
                          64'(rsp_data.table_full));
               note_field("function_found", 64'(want_rsp.function_found),
                          64'(rsp_data.function_found));
               note_field("function_slot", 64'(want_rsp.function_slot),
                          64'(rsp_data.function_slot));
               note_field("function_start", want_rsp.function_start,
                          rsp_data.function_start);
               note_field("function_length", 64'(want_rsp.function_length),
                          64'(rsp_data.function_length));
               note_field("line_found", 64'(want_rsp.line_found),
                          64'(rsp_data.line_found));
               note_field("line_out", 64'(want_rsp.line_out), 64'(rsp_data.line_out));
               note_field("column_out", 64'(want_rsp.column_out),
                          64'(rsp_data.column_out));
               note_field("file_out", 64'(want_rsp.file_out), 64'(rsp_data.file_out));
            end
         end
      end
   end

   // Stall the result side at random unless a steady stretch is running
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 11);
   end

   // Abort when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Send one request beat, idling first at random; valid stays up on return
   task automatic send_beat(input astl_pkg::req_type item);
      while (!steady_flow && $urandom_range(0, 99) < 11) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register access: setup then access cycle; a read is checked
   task automatic csr_access(input bit is_write,
                             input logic [astl_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= LOAD_BASE_ADDR;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (is_write)
         base_shadow = data;
      else
         note_field("load_base", base_shadow, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_load_base(input logic [63:0] value);
      drain();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   function automatic astl_pkg::req_type make_beat(input logic [1:0] cmd,
                                                   input logic [63:0] addr,
                                                   input logic [31:0] len,
                                                   input logic [23:0] line_no,
                                                   input logic [15:0] col,
                                                   input logic [15:0] file);
      astl_pkg::req_type item;
      item.command = cmd;
      item.address = addr;
      item.length = len;
      item.line_number = line_no;
      item.column_number = col;
      item.file_index = file;
      return item;
   endfunction

   // Random beat around a window; pick selects the kind (0..99)
   function automatic astl_pkg::req_type random_beat(input logic [63:0] window, input int pick);
      astl_pkg::req_type item;
      int len_pick;
      item = make_beat(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom,
                       24'($urandom), 16'($urandom), 16'($urandom));
      len_pick = $urandom_range(0, 99);
      if (pick < 24) begin
         item.command = astl_pkg::CMD_ADD_FUNC;
         item.address = window + 64'($urandom_range(0, 'h3000));
         if (len_pick < 85)
            item.length = $urandom_range(0, 'h400);
         else if (len_pick >= 96)
            item.length = '1;
      end else if (pick < 50) begin
         item.command = astl_pkg::CMD_ADD_LINE;
         item.address = window + 64'($urandom_range(0, 'h3400));
      end else if (pick < 94) begin
         item.command = astl_pkg::CMD_QUERY;
         item.address = base_shadow + window + 64'($urandom_range(0, 'h3800));
      end else if (pick >= 97) begin
         item.command = CMD_UNUSED;
      end
      return item;
   endfunction

   // Query and unused command on empty tables
   task automatic test_empty_and_unused;
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1000, '0, '0, '0, '0));
      send_beat(make_beat(CMD_UNUSED, ALL_ONES, '1, '1, '1, '1));
      drain();
   endtask

   // Function ranges: exact start, end of span, past the end, ties, no wrap
   task automatic test_function_ranges;
      send_beat(make_beat(astl_pkg::CMD_ADD_FUNC, 64'h1000, 32'h100, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_ADD_FUNC, 64'h1000, 32'h10, '1, '1, '1));
      send_beat(make_beat(astl_pkg::CMD_ADD_FUNC, 64'hFFFF_FFFF_FFFF_FF00, '1, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_ADD_FUNC, '0, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1000, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1100, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1101, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, '0, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h800, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, ALL_ONES, '1, '1, '1, '1));
      drain();
   endtask

   // Line records: at the function start, ties, outside the span, field extremes
   task automatic test_line_records;
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'h1000, '0, 24'd10, 16'd1, 16'd1));
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'h1080, '0, 24'd20, 16'd2, 16'd2));
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'h1080, '0, 24'd30, 16'd3, 16'd3));
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'h1200, '0, 24'd40, 16'd4, 16'd4));
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'hFFFF_FFFF_FFFF_FFF0, '0, '1, '1, '1));
      send_beat(make_beat(astl_pkg::CMD_ADD_LINE, 64'h1100, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1081, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1080, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'h1000, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, ALL_ONES, '0, '0, '0, '0));
      drain();
   endtask

   // Load base subtraction wraps around zero
   task automatic test_load_base_wrap;
      set_load_base(ALL_ONES);
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'hFFF, '0, '0, '0, '0));
      send_beat(make_beat(astl_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0, '0));
      drain();
   endtask

   // Random traffic in phases, each with its own load base and address window
   task automatic test_random_traffic;
      logic [63:0] phase_base [5];
      logic [63:0] window;
      int phase;
      int n;
      phase_base[0] = '0;
      phase_base[1] = ALL_ONES;
      phase_base[2] = {$urandom, $urandom};
      phase_base[3] = 64'h8000_0000_0000_0000;
      phase_base[4] = {$urandom, $urandom};
      for (phase = 0; phase < 5; phase++) begin
         set_load_base(phase_base[phase]);
         window = {$urandom, $urandom};
         steady_flow = (phase == 2);
         for (n = 0; n < 100; n++)
            send_beat(random_beat(window, $urandom_range(0, 99)));
         drain();
         steady_flow = 1'b0;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_unused();
      test_function_ranges();
      test_line_records();
      test_load_base_wrap();
      test_random_traffic();

      // hold a while to catch stray result beats
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
rtl/core/astl_pkg.sv
rtl/core/astl_scan_cmp.sv
rtl/core/address_to_symbol_lookup.sv
bench/tb.sv
